// ----- src/mrp_pkg.sv -----
// Shared types and constants for the multibulk request parser.
package mrp_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int LENGTH_BITS = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [1:0] MIN_ARG_LINE_POS = 2'd3;
  localparam int         TRAIL_BYTES      = 2;

  localparam logic [15:0] MAX_ARG_COUNT_RESET   = 16'd1024;
  localparam logic [29:0] MAX_BULK_LENGTH_RESET = 30'd536870912;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ARGLINE,
    PH_PAYLOAD,
    PH_TRAIL,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD,
    EV_EMPTY,
    EV_NULL,
    EV_DONE,
    EV_WRONG,
    EV_NUMERR,
    EV_LIMIT
  } event_t;

  typedef enum logic [1:0] {
    NS_NONE,
    NS_SIGN,
    NS_DIGITS,
    NS_STOP
  } num_state_t;

  typedef enum logic [0:0] {
    REG_MAX_ARG_COUNT,
    REG_MAX_BULK_LENGTH
  } reg_index_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  payload_byte;
    logic [15:0] arg_index;
    logic        arg_end;
    logic [15:0] arg_total;
    logic        two;
    logic [15:0] done_total;
  } rec_t;

endpackage

// ----- src/mrp_front.sv -----
// Front part: byte parser state, configuration registers and result records.
module mrp_front import mrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [29:0] cfg_data,
  input  logic [7:0]  data_byte,
  input  logic        accept,
  output rec_t        rec,
  output logic        rec_valid
);

  logic [15:0]            max_arg_count;
  logic [29:0]            max_bulk_length;

  phase_t                 phase, phase_next;
  logic [1:0]             pos, pos_next;
  logic [7:0]             first_char, first_char_next;
  logic [7:0]             held_char, held_char_next;
  logic [31:0]            num_value, num_value_next;
  logic                   num_neg, num_neg_next;
  num_state_t             num_state, num_state_next;
  logic [COUNT_BITS-1:0]  args_expected, args_expected_next;
  logic [COUNT_BITS-1:0]  args_done, args_done_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;

  logic                   is_digit;
  logic [35:0]            prod;
  logic [31:0]            sat_value;
  logic [31:0]            fed_value;
  logic                   fed_neg;
  num_state_t             fed_state;

  logic [7:0]             first_eff;
  logic                   neg_val;
  logic                   num_ok;
  logic                   count_over;
  logic                   len_over;
  logic [COUNT_BITS-1:0]  done_inc;
  logic                   last_arg;

  assign is_digit  = (held_char >= CHAR_ZERO) && (held_char <= CHAR_NINE);
  assign prod      = ({4'b0, num_value} << 3) + ({4'b0, num_value} << 1)
                     + {32'b0, held_char[3:0]};
  assign sat_value = (prod[35:32] != 4'b0) ? '1 : prod[31:0];

  always_comb begin
    fed_value = num_value;
    fed_neg   = num_neg;
    fed_state = num_state;
    case (num_state)
      NS_NONE, NS_SIGN: begin
        if (num_state == NS_NONE && held_char == CHAR_MINUS) begin
          fed_neg   = 1'b1;
          fed_state = NS_SIGN;
        end else if (is_digit) begin
          fed_value = {28'b0, held_char[3:0]};
          fed_state = NS_DIGITS;
        end else begin
          fed_value = '1;
          fed_neg   = 1'b0;
          fed_state = NS_STOP;
        end
      end
      NS_DIGITS: begin
        if (is_digit) begin
          fed_value = sat_value;
        end else begin
          fed_state = NS_STOP;
        end
      end
      default: ;
    endcase
  end

  assign first_eff  = (pos == 2'd0) ? CHAR_LF : first_char;
  assign neg_val    = num_neg && (num_value != 32'd0);
  assign num_ok     = (num_state == NS_DIGITS || num_state == NS_STOP)
                      && (num_value <= (num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF));
  assign count_over = (num_value > {16'b0, max_arg_count})
                      || ((num_value >> COUNT_BITS) != 32'd0);
  assign len_over   = (num_value > {2'b0, max_bulk_length})
                      || ((num_value >> LENGTH_BITS) != 32'd0);
  assign done_inc   = args_done + 1'b1;
  assign last_arg   = done_inc >= args_expected;

  always_comb begin
    phase_next         = phase;
    pos_next           = pos;
    first_char_next    = first_char;
    held_char_next     = held_char;
    num_value_next     = num_value;
    num_neg_next       = num_neg;
    num_state_next     = num_state;
    args_expected_next = args_expected;
    args_done_next     = args_done;
    bytes_left_next    = bytes_left;
    rec                = '0;
    rec_valid          = 1'b0;
    rec.done_total     = 16'(args_expected);
    case (phase)
      PH_HALT: ;
      PH_PAYLOAD: begin
        rec_valid        = 1'b1;
        rec.event_res    = EV_PAYLOAD;
        rec.payload_byte = data_byte;
        rec.arg_index    = 16'(args_done);
        rec.arg_end      = bytes_left <= LENGTH_BITS'(1);
        if (rec.arg_end) begin
          bytes_left_next = LENGTH_BITS'(TRAIL_BYTES);
          phase_next      = PH_TRAIL;
        end else begin
          bytes_left_next = bytes_left - 1'b1;
        end
      end
      PH_TRAIL: begin
        if (bytes_left > LENGTH_BITS'(1)) begin
          bytes_left_next = bytes_left - 1'b1;
        end else begin
          bytes_left_next = '0;
          args_done_next  = done_inc;
          if (last_arg) begin
            rec_valid          = 1'b1;
            rec.event_res      = EV_DONE;
            rec.arg_total      = 16'(args_expected);
            args_expected_next = '0;
            args_done_next     = '0;
            phase_next         = PH_HEADER;
          end else begin
            phase_next = PH_ARGLINE;
          end
        end
      end
      PH_HEADER, PH_ARGLINE: begin
        if (data_byte == CHAR_LF) begin
          pos_next        = '0;
          first_char_next = '0;
          held_char_next  = '0;
          num_value_next  = '0;
          num_neg_next    = 1'b0;
          num_state_next  = NS_NONE;
          if (phase == PH_HEADER) begin
            if (first_eff != CHAR_STAR) begin
              rec_valid     = 1'b1;
              rec.event_res = EV_WRONG;
            end else if (!num_ok || neg_val) begin
              rec_valid     = 1'b1;
              rec.event_res = EV_NUMERR;
              phase_next    = PH_HALT;
            end else if (count_over) begin
              rec_valid     = 1'b1;
              rec.event_res = EV_LIMIT;
              phase_next    = PH_HALT;
            end else if (num_value == 32'd0) begin
              rec_valid     = 1'b1;
              rec.event_res = EV_DONE;
            end else begin
              args_expected_next = num_value[COUNT_BITS-1:0];
              args_done_next     = '0;
              phase_next         = PH_ARGLINE;
            end
          end else begin
            rec.arg_index = 16'(args_done);
            if (pos < MIN_ARG_LINE_POS || first_eff != CHAR_DOLLAR) begin
              rec_valid          = 1'b1;
              rec.event_res      = EV_WRONG;
              args_expected_next = '0;
              args_done_next     = '0;
              bytes_left_next    = '0;
              phase_next         = PH_HEADER;
            end else if (!num_ok || (neg_val && num_value != 32'd1)) begin
              rec_valid     = 1'b1;
              rec.event_res = EV_NUMERR;
              phase_next    = PH_HALT;
            end else if (neg_val) begin
              rec_valid      = 1'b1;
              rec.event_res  = EV_NULL;
              args_done_next = done_inc;
              if (last_arg) begin
                rec.two            = 1'b1;
                args_expected_next = '0;
                args_done_next     = '0;
                bytes_left_next    = '0;
                phase_next         = PH_HEADER;
              end
            end else if (len_over) begin
              rec_valid     = 1'b1;
              rec.event_res = EV_LIMIT;
              phase_next    = PH_HALT;
            end else if (num_value == 32'd0) begin
              rec_valid       = 1'b1;
              rec.event_res   = EV_EMPTY;
              bytes_left_next = LENGTH_BITS'(TRAIL_BYTES);
              phase_next      = PH_TRAIL;
            end else begin
              bytes_left_next = num_value[LENGTH_BITS-1:0];
              phase_next      = PH_PAYLOAD;
            end
          end
        end else begin
          if (pos == 2'd0) begin
            first_char_next = data_byte;
          end else begin
            if (pos >= 2'd2) begin
              num_value_next = fed_value;
              num_neg_next   = fed_neg;
              num_state_next = fed_state;
            end
            held_char_next = data_byte;
          end
          if (pos != 2'd3) begin
            pos_next = pos + 1'b1;
          end
        end
      end
      default: begin
        phase_next         = PH_HEADER;
        pos_next           = '0;
        first_char_next    = '0;
        held_char_next     = '0;
        num_value_next     = '0;
        num_neg_next       = 1'b0;
        num_state_next     = NS_NONE;
        args_expected_next = '0;
        args_done_next     = '0;
        bytes_left_next    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_count   <= MAX_ARG_COUNT_RESET;
      max_bulk_length <= MAX_BULK_LENGTH_RESET;
      phase           <= PH_HEADER;
      pos             <= '0;
      first_char      <= '0;
      held_char       <= '0;
      num_value       <= '0;
      num_neg         <= 1'b0;
      num_state       <= NS_NONE;
      args_expected   <= '0;
      args_done       <= '0;
      bytes_left      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_ARG_COUNT) begin
          max_arg_count <= cfg_data[15:0];
        end else begin
          max_bulk_length <= cfg_data;
        end
      end
      if (accept) begin
        phase         <= phase_next;
        pos           <= pos_next;
        first_char    <= first_char_next;
        held_char     <= held_char_next;
        num_value     <= num_value_next;
        num_neg       <= num_neg_next;
        num_state     <= num_state_next;
        args_expected <= args_expected_next;
        args_done     <= args_done_next;
        bytes_left    <= bytes_left_next;
      end
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("parser left halt without reset");

  a_two_only_null: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.two |-> rec.event_res == EV_NULL)
    else $error("two results from a non-null event");

  a_arg_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD || phase == PH_TRAIL) |-> args_done < args_expected)
    else $error("argument index beyond count");

endmodule

// ----- src/mrp_queue.sv -----
// Result record queue between the parser and the output side.
module mrp_queue import mrp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic head_valid,
  output logic not_full
);

  rec_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign head       = entries[rd_ptr];
  assign head_valid = count != '0;
  assign not_full   = count != (QUEUE_AW + 1)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> not_full)
    else $error("push into full queue");

endmodule

// ----- src/mrp_back.sv -----
// Back part: splits queued records into output beats.
module mrp_back import mrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rec_t        head,
  input  logic        head_valid,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  logic        second;
  event_t      ev;
  logic [7:0]  payload_byte;
  logic [15:0] arg_index;
  logic        arg_end;
  logic [15:0] arg_total;

  always_comb begin
    if (second) begin
      ev           = EV_DONE;
      payload_byte = '0;
      arg_index    = '0;
      arg_end      = 1'b0;
      arg_total    = head.done_total;
      m_tlast      = 1'b1;
    end else begin
      ev           = head.event_res;
      payload_byte = head.payload_byte;
      arg_index    = head.arg_index;
      arg_end      = head.arg_end;
      arg_total    = head.arg_total;
      m_tlast      = !head.two;
    end
  end

  assign m_tvalid = head_valid;
  assign m_tuser  = ev;
  assign m_tdata  = {7'b0, arg_total, arg_end, arg_index, payload_byte};
  assign pop      = head_valid && m_tready && (!head.two || second);

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (head_valid && m_tready) begin
      second <= head.two && !second;
    end
  end

  a_second_has_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> head_valid && head.two)
    else $error("second beat without a paired record");

endmodule

// ----- src/multibulk_request_parser_unit.sv -----
// Top level of the multibulk request parser.
// Takes one request byte per cycle on s_*: every byte is parsed in the cycle
// it is accepted, so the input rate is one byte per clock while s_tready is
// high. Results leave on m_* through a four-entry record queue; s_tready drops
// only while that queue is full. A byte gives at most two output beats (a null
// argument that ends its command is followed by the complete beat), so such a
// byte's record is popped after both beats. After a number or limit error the
// unit keeps accepting bytes but drops them without output until reset.
module multibulk_request_parser_unit import mrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] payload_byte, [23:8] arg_index,
                                 // [24] arg_end, [40:25] arg_total, rest zero
  output logic [2:0]  m_tuser,   // [2:0] event_res
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [29:0] cfg_data
);

  logic accept;
  rec_t rec;
  logic rec_valid;
  rec_t head;
  logic head_valid;
  logic pop;
  logic not_full;

  assign s_tready = not_full;
  assign accept   = s_tvalid && s_tready;

  mrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_byte (s_tdata),
    .accept    (accept),
    .rec       (rec),
    .rec_valid (rec_valid)
  );

  mrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && rec_valid),
    .push_rec   (rec),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .not_full   (not_full)
  );

  mrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
